// ===== hdl/slm_pkg.sv =====
// ----------------------------------------------------------------------------
// slm_pkg: shared types and codes for the slot linked list manager
// Request and response words, operation codes and status codes.
// ----------------------------------------------------------------------------
package slm_pkg;

  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_DELETE = 2'd1;
  localparam logic [1:0] ACT_READ   = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_MISSING = 2'd2;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] item_value;
    logic [5:0]  slot_index;
  } slm_req_t;

  typedef struct packed {
    logic [5:0]  result_slot;
    logic [31:0] result_value;
    logic [1:0]  status;
    logic [6:0]  used_count;
  } slm_rsp_t;

endpackage

// ===== hdl/slot_linked_list_manager.sv =====
// Sequence: insert, read and delete of the used-list head pass through S_INS,
//   S_READ or S_DEL_HEAD to S_RESULT; full, missing or no-op words go straight
//   to S_RESULT; other deletes walk in S_WALK and, on a match, S_UNLINK and S_RELINK.
// Throughput: one word at a time; the delete walk reads one link per cycle.
// Reset: synchronous; lists return to their initial threading at once via a
//   fill mark, with no clearing pass over the slot memories.
// ----------------------------------------------------------------------------
// slot_linked_list_manager: slot table threaded into used and free lists
// Sequencer, slot store and a response register that frees the sequencer.
// ----------------------------------------------------------------------------
module slot_linked_list_manager #(
  parameter int CAPACITY = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_ready,
  input  slm_pkg::slm_req_t req,
  output logic             rsp_valid,
  input  logic             rsp_ready,
  output slm_pkg::slm_rsp_t rsp
);

  import slm_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int LW = $clog2(CAPACITY + 1);

  slm_rsp_t      res;
  logic          res_valid;
  logic          load;
  logic [AW-1:0] rd_addr;
  logic [31:0]   rd_value;
  logic [LW-1:0] rd_link;
  logic [AW-1:0] wr_addr;
  logic          val_we;
  logic          link_we;
  logic [31:0]   wr_value;
  logic [LW-1:0] wr_link;

  assign load = res_valid && (!rsp_valid || rsp_ready);

  slm_ctrl #(.CAPACITY(CAPACITY)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .res_valid (res_valid),
    .res_take  (load),
    .res       (res),
    .rd_addr   (rd_addr),
    .rd_value  (rd_value),
    .rd_link   (rd_link),
    .wr_addr   (wr_addr),
    .val_we    (val_we),
    .link_we   (link_we),
    .wr_value  (wr_value),
    .wr_link   (wr_link)
  );

  slm_store #(.CAPACITY(CAPACITY)) u_store (
    .clk      (clk),
    .rst      (rst),
    .rd_addr  (rd_addr),
    .rd_value (rd_value),
    .rd_link  (rd_link),
    .wr_addr  (wr_addr),
    .val_we   (val_we),
    .link_we  (link_we),
    .wr_value (wr_value),
    .wr_link  (wr_link)
  );

  // hold the response word until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rsp <= res;
    end
  end

endmodule

// ===== hdl/slm_store.sv =====
// ----------------------------------------------------------------------------
// slm_store: slot value and link memories
// Two synchronous memories sharing one read and one write address. A fill
// mark stands in for the reset contents of slots never written.
// ----------------------------------------------------------------------------
module slm_store #(
  parameter  int CAPACITY = 64,
  localparam int AW = $clog2(CAPACITY),
  localparam int LW = $clog2(CAPACITY + 1)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic [AW-1:0] rd_addr,
  output logic [31:0]   rd_value,
  output logic [LW-1:0] rd_link,
  input  logic [AW-1:0] wr_addr,
  input  logic          val_we,
  input  logic          link_we,
  input  logic [31:0]   wr_value,
  input  logic [LW-1:0] wr_link
);

  logic [31:0]   val_mem  [CAPACITY];
  logic [LW-1:0] link_mem [CAPACITY];
  logic [31:0]   val_q;
  logic [LW-1:0] link_q;
  logic [AW-1:0] addr_q;
  logic          fresh_q;
  logic [LW-1:0] fill;

  always_ff @(posedge clk) begin
    if (val_we) begin
      val_mem[wr_addr] <= wr_value;
    end
    if (link_we) begin
      link_mem[wr_addr] <= wr_link;
    end
    val_q   <= val_mem[rd_addr];
    link_q  <= link_mem[rd_addr];
    addr_q  <= rd_addr;
    fresh_q <= (LW'(rd_addr) >= fill);
  end

  // advance the fill mark past every slot that takes a value
  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (val_we && (LW'(wr_addr) >= fill)) begin
      fill <= LW'(wr_addr) + LW'(1);
    end
  end

  assign rd_value = fresh_q ? '0 : val_q;
  assign rd_link  = fresh_q ? (LW'(addr_q) + LW'(1)) : link_q;

endmodule

// ===== hdl/slm_ctrl.sv =====
// ----------------------------------------------------------------------------
// slm_ctrl: list sequencer
// Holds the list heads and occupancy, runs insert, delete walk and read
// against the slot store, and builds the response word.
// ----------------------------------------------------------------------------
module slm_ctrl #(
  parameter  int CAPACITY = 64,
  localparam int AW = $clog2(CAPACITY),
  localparam int LW = $clog2(CAPACITY + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_ready,
  input  slm_pkg::slm_req_t req,
  output logic             res_valid,
  input  logic             res_take,
  output slm_pkg::slm_rsp_t res,
  output logic [AW-1:0]    rd_addr,
  input  logic [31:0]      rd_value,
  input  logic [LW-1:0]    rd_link,
  output logic [AW-1:0]    wr_addr,
  output logic             val_we,
  output logic             link_we,
  output logic [31:0]      wr_value,
  output logic [LW-1:0]    wr_link
);

  import slm_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_INS      = 8'b0000_0010,
    S_DEL_HEAD = 8'b0000_0100,
    S_WALK     = 8'b0000_1000,
    S_UNLINK   = 8'b0001_0000,
    S_RELINK   = 8'b0010_0000,
    S_READ     = 8'b0100_0000,
    S_RESULT   = 8'b1000_0000
  } state_t;

  localparam logic [LW-1:0] NONE = LW'(CAPACITY);

  state_t        state;
  state_t        state_next;
  logic [LW-1:0] used_head;
  logic [LW-1:0] free_head;
  logic [LW-1:0] occ;
  logic [LW-1:0] cur;
  logic [LW-1:0] steps;
  logic [31:0]   item;
  logic [5:0]    idx_raw;
  logic [AW-1:0] idx_a;
  logic [AW-1:0] in_idx_a;
  logic          in_idx_ok;
  logic          full;
  logic          head_hit;
  logic          walk_hit;
  logic          walk_end;
  logic [LW-1:0] steps_inc;

  assign in_idx_a  = AW'(req.slot_index);
  assign in_idx_ok = (32'(req.slot_index) < 32'(CAPACITY));
  assign full      = (occ >= NONE) || (free_head >= NONE);
  assign head_hit  = (used_head == LW'(in_idx_a));
  assign idx_a     = AW'(idx_raw);
  assign walk_hit  = (rd_link == LW'(idx_a));
  assign steps_inc = steps + LW'(1);
  assign walk_end  = (rd_link >= NONE) || (steps_inc >= NONE);

  assign req_ready = (state == S_IDLE);
  assign res_valid = (state == S_RESULT);
  assign wr_value  = item;

  always_comb begin
    state_next = state;
    rd_addr    = '0;
    wr_addr    = idx_a;
    val_we     = 1'b0;
    link_we    = 1'b0;
    wr_link    = free_head;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          case (req.action)
            ACT_INSERT: begin
              if (!full) begin
                rd_addr    = AW'(free_head);
                state_next = S_INS;
              end else begin
                state_next = S_RESULT;
              end
            end
            ACT_DELETE: begin
              if (!in_idx_ok || (occ == '0)) begin
                state_next = S_RESULT;
              end else if (head_hit) begin
                rd_addr    = in_idx_a;
                state_next = S_DEL_HEAD;
              end else begin
                rd_addr    = AW'(used_head);
                state_next = S_WALK;
              end
            end
            ACT_READ: begin
              if (in_idx_ok) begin
                rd_addr    = in_idx_a;
                state_next = S_READ;
              end else begin
                state_next = S_RESULT;
              end
            end
            default: state_next = S_RESULT;
          endcase
        end
      end
      S_INS: begin
        val_we     = 1'b1;
        link_we    = 1'b1;
        wr_addr    = AW'(free_head);
        wr_link    = used_head;
        state_next = S_RESULT;
      end
      S_DEL_HEAD: begin
        link_we    = 1'b1;
        state_next = S_RESULT;
      end
      S_WALK: begin
        if (walk_hit) begin
          rd_addr    = idx_a;
          state_next = S_UNLINK;
        end else if (walk_end) begin
          state_next = S_RESULT;
        end else begin
          rd_addr = AW'(rd_link);
        end
      end
      S_UNLINK: begin
        link_we    = 1'b1;
        wr_addr    = AW'(cur);
        wr_link    = rd_link;
        state_next = S_RELINK;
      end
      S_RELINK: begin
        link_we    = 1'b1;
        state_next = S_RESULT;
      end
      S_READ: begin
        state_next = S_RESULT;
      end
      S_RESULT: begin
        if (res_take) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      used_head <= NONE;
      free_head <= '0;
      occ       <= '0;
    end else begin
      state <= state_next;
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            item             <= req.item_value;
            idx_raw          <= req.slot_index;
            cur              <= used_head;
            steps            <= '0;
            res.result_slot  <= req.slot_index;
            res.result_value <= '0;
            res.status       <= ST_OK;
            res.used_count   <= 7'(occ);
            case (req.action)
              ACT_INSERT: begin
                if (full) begin
                  res.result_slot <= '0;
                  res.status      <= ST_FULL;
                end
              end
              ACT_DELETE: begin
                if (!in_idx_ok || (occ == '0)) begin
                  res.status <= ST_MISSING;
                end
              end
              default: ;
            endcase
          end
        end
        S_INS: begin
          free_head       <= rd_link;
          used_head       <= free_head;
          occ             <= occ + LW'(1);
          res.result_slot <= 6'(free_head);
          res.used_count  <= 7'(occ + LW'(1));
        end
        S_DEL_HEAD: begin
          used_head      <= rd_link;
          free_head      <= LW'(idx_a);
          occ            <= occ - LW'(1);
          res.used_count <= 7'(occ - LW'(1));
        end
        S_WALK: begin
          if (!walk_hit) begin
            if (walk_end) begin
              res.status <= ST_MISSING;
            end else begin
              cur   <= rd_link;
              steps <= steps_inc;
            end
          end
        end
        S_RELINK: begin
          free_head      <= LW'(idx_a);
          occ            <= occ - LW'(1);
          res.used_count <= 7'(occ - LW'(1));
        end
        S_READ: begin
          res.result_value <= rd_value;
        end
        default: ;
      endcase
    end
  end

  a_occ_range: assert property (@(posedge clk) disable iff (rst)
    occ <= NONE) else $error("occupancy above capacity");

  a_free_empty: assert property (@(posedge clk) disable iff (rst)
    (free_head == NONE) == (occ == NONE)) else $error("free list out of step with occupancy");

  a_used_empty: assert property (@(posedge clk) disable iff (rst)
    (used_head == NONE) == (occ == '0)) else $error("used list out of step with occupancy");

  a_walk_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK) |-> (steps < NONE)) else $error("walk ran past capacity");

  a_ins_slot: assert property (@(posedge clk) disable iff (rst)
    (state == S_INS) |-> (free_head < NONE)) else $error("insert without a free slot");

endmodule
